// ----- design/text_terminal_writer_defines.svh -----
// ----------------------------------------------------------------------------
// text terminal writer assertion macros
// immediate-style wrappers around concurrent assertions, empty for synthesis
// ----------------------------------------------------------------------------
`ifndef TEXT_TERMINAL_WRITER_DEFINES_SVH
`define TEXT_TERMINAL_WRITER_DEFINES_SVH
`ifndef SYNTHESIS
`define TTW_ASSERT_IMPL(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error(msg);
`define TTW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error(msg);
`else
`define TTW_ASSERT_IMPL(label, clk, rstn, ante, cons, msg)
`define TTW_ASSERT_NEXT(label, clk, rstn, ante, cons, msg)
`endif
`endif

// ----- design/ttw_pkg.sv -----
// ----------------------------------------------------------------------------
// ttw_pkg
// shared constants, codes and the command format of the text terminal writer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package ttw_pkg;

    localparam int COLUMNS_DEFAULT     = 80;
    localparam int ROWS_DEFAULT        = 25;
    localparam int QUEUE_DEPTH_DEFAULT = 4;

    localparam int ROW_W   = 5;
    localparam int COL_W   = 7;
    localparam int CODE_W  = 8;
    localparam int INDEX_W = 11;
    localparam int KIND_W  = 2;
    localparam int DATA_W  = 16;
    localparam int ATTR_W  = 8;

    localparam logic [CODE_W-1:0] LINE_FEED  = 8'd10;
    localparam logic [CODE_W-1:0] SPACE_CODE = 8'd32;
    localparam logic [ATTR_W-1:0] ATTR_RESET = 8'd7;

    localparam logic [KIND_W-1:0] KIND_PUT   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_CLEAR = 2'd1;
    localparam logic [KIND_W-1:0] KIND_READ  = 2'd2;

    typedef enum logic [2:0] {
        OP_PUT,
        OP_FEED,
        OP_CLEAR,
        OP_READ,
        OP_NONE
    } op_t;

    typedef struct packed {
        op_t               op;
        logic [CODE_W-1:0] code;
        logic [ROW_W-1:0]  row;
        logic [COL_W-1:0]  col;
        logic              outside;
    } cmd_t;

endpackage

// ----- design/ttw_front.sv -----
// ----------------------------------------------------------------------------
// ttw_front
// accepts input transfers, decodes the kind and splits a read index into
// row and column by repeated subtraction
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttw_front #(
    parameter int COLUMNS = ttw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = ttw_pkg::ROWS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [ttw_pkg::KIND_W-1:0]   s_kind,
    input  logic [ttw_pkg::CODE_W-1:0]   s_code,
    input  logic [ttw_pkg::INDEX_W-1:0]  s_index,
    output logic                         q_valid,
    input  logic                         q_ready,
    output ttw_pkg::cmd_t                q_cmd
);
    import ttw_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int CELLS = ROWS * COLUMNS;

    typedef enum logic [1:0] {
        F_IDLE,
        F_DIV,
        F_PUSH
    } fstate_t;

    fstate_t             state_reg, state_next;
    cmd_t                cmd_reg, cmd_next;
    logic [INDEX_W-1:0]  rem_reg, rem_next;
    logic [RW-1:0]       quo_reg, quo_next;

    assign s_tready = (state_reg == F_IDLE);
    assign q_valid  = (state_reg == F_PUSH);
    assign q_cmd    = cmd_reg;

    always_comb begin
        state_next = state_reg;
        cmd_next   = cmd_reg;
        rem_next   = rem_reg;
        quo_next   = quo_reg;
        case (state_reg)
            F_IDLE: begin
                if (s_tvalid) begin
                    cmd_next.code    = s_code;
                    cmd_next.row     = '0;
                    cmd_next.col     = '0;
                    cmd_next.outside = 1'b0;
                    rem_next         = s_index;
                    quo_next         = '0;
                    state_next       = F_PUSH;
                    case (s_kind)
                        KIND_PUT: begin
                            cmd_next.op = (s_code == LINE_FEED) ? OP_FEED : OP_PUT;
                        end
                        KIND_CLEAR: begin
                            cmd_next.op = OP_CLEAR;
                        end
                        KIND_READ: begin
                            cmd_next.op = OP_READ;
                            if (32'(s_index) >= 32'(CELLS)) begin
                                cmd_next.outside = 1'b1;
                            end else begin
                                state_next = F_DIV;
                            end
                        end
                        default: begin
                            cmd_next.op = OP_NONE;
                        end
                    endcase
                end
            end
            F_DIV: begin
                // one subtraction of a row width per cycle
                if (rem_reg >= INDEX_W'(COLUMNS)) begin
                    rem_next = rem_reg - INDEX_W'(COLUMNS);
                    quo_next = quo_reg + 1'b1;
                end else begin
                    cmd_next.row = ROW_W'(quo_reg);
                    cmd_next.col = COL_W'(rem_reg[CW-1:0]);
                    state_next   = F_PUSH;
                end
            end
            F_PUSH: begin
                if (q_ready) begin
                    state_next = F_IDLE;
                end
            end
            default: begin
                state_next = F_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= F_IDLE;
        end else begin
            state_reg <= state_next;
        end
        cmd_reg <= cmd_next;
        rem_reg <= rem_next;
        quo_reg <= quo_next;
    end

endmodule

// ----- design/ttw_queue.sv -----
// ----------------------------------------------------------------------------
// ttw_queue
// small command fifo between the decoder and the screen engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module ttw_queue #(
    parameter int DEPTH = ttw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          in_valid,
    output logic          in_ready,
    input  ttw_pkg::cmd_t in_cmd,
    output logic          out_valid,
    input  logic          out_ready,
    output ttw_pkg::cmd_t out_cmd
);
    import ttw_pkg::*;

    localparam int PW = $clog2(DEPTH);
    localparam int NW = $clog2(DEPTH + 1);

    cmd_t            entries_reg [DEPTH];
    logic [PW-1:0]   wr_ptr_reg, rd_ptr_reg;
    logic [NW-1:0]   count_reg;
    logic            push, pop;

    assign in_ready  = (count_reg != NW'(DEPTH));
    assign out_valid = (count_reg != '0);
    assign out_cmd   = entries_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
            end
            if (push && !pop) begin
                count_reg <= count_reg + 1'b1;
            end else if (pop && !push) begin
                count_reg <= count_reg - 1'b1;
            end
        end
        if (push) begin
            entries_reg[wr_ptr_reg] <= in_cmd;
        end
    end

endmodule

// ----- design/ttw_back.sv -----
// ----------------------------------------------------------------------------
// ttw_back
// screen engine: cursor, ring of rows with a top-row offset, cell memory and
// the result register
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "text_terminal_writer_defines.svh"

module ttw_back #(
    parameter int COLUMNS = ttw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS    = ttw_pkg::ROWS_DEFAULT
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic [ttw_pkg::ATTR_W-1:0]   attr,
    input  logic                         q_valid,
    input  ttw_pkg::cmd_t                q_cmd,
    output logic                         q_pop,
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [ttw_pkg::DATA_W-1:0]   m_read_data,
    output logic [ttw_pkg::ROW_W-1:0]    m_cursor_row,
    output logic [ttw_pkg::COL_W-1:0]    m_cursor_column
);
    import ttw_pkg::*;

    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);
    localparam int SW    = RW + 1;
    localparam int AW    = RW + CW;
    localparam int DEPTH = ROWS * (1 << CW);

    typedef enum logic [1:0] {
        B_IDLE,
        B_EXEC,
        B_FILL,
        B_READ
    } bstate_t;

    bstate_t            state_reg, state_next;
    cmd_t               cmd_reg, cmd_next;
    logic [RW-1:0]      row_reg, row_next;
    logic [CW-1:0]      col_reg, col_next;
    logic [RW-1:0]      top_reg, top_next;
    // per physical row: cells held in memory, else a virtual blank row
    logic [ROWS-1:0]    mat_reg, mat_next;
    // virtual blank row is spaces in the clear attribute, else zeros
    logic [ROWS-1:0]    spc_reg, spc_next;
    logic [ATTR_W-1:0]  clr_attr_reg, clr_attr_next;
    logic [RW-1:0]      phys_reg, phys_next;
    logic [CW-1:0]      fill_reg, fill_next;
    logic               out_valid_reg, out_valid_next;
    logic [DATA_W-1:0]  out_data_reg, out_data_next;
    logic [RW-1:0]      out_row_reg, out_row_next;
    logic [CW-1:0]      out_col_reg, out_col_next;

    logic [DATA_W-1:0]  mem [DEPTH];
    logic [DATA_W-1:0]  rd_reg;
    logic               mem_we;
    logic [AW-1:0]      mem_wa, mem_ra;
    logic [DATA_W-1:0]  mem_wd;

    logic [RW-1:0]      lrow;
    logic [CW-1:0]      lcol;
    logic [SW-1:0]      row_sum;
    logic [RW-1:0]      phys;
    logic [RW-1:0]      blank_row;
    logic [DATA_W-1:0]  virt_val;
    logic [DATA_W-1:0]  put_val;
    logic               do_step, step_feed, scroll;
    logic [RW-1:0]      row_step, top_step;
    logic [CW-1:0]      col_step;
    logic               emit;
    logic [DATA_W-1:0]  emit_data;

    assign lrow    = (cmd_reg.op == OP_READ) ? cmd_reg.row[RW-1:0] : row_reg;
    assign lcol    = (cmd_reg.op == OP_READ) ? cmd_reg.col[CW-1:0] : col_reg;
    assign row_sum = {1'b0, top_reg} + {1'b0, lrow};
    assign phys    = (row_sum >= SW'(ROWS)) ? RW'(row_sum - SW'(ROWS)) : row_sum[RW-1:0];

    assign blank_row = (state_reg == B_FILL) ? phys_reg : phys;
    assign virt_val  = spc_reg[blank_row] ? {clr_attr_reg, SPACE_CODE} : '0;
    assign put_val   = {attr, cmd_reg.code};

    // cursor advance, with scroll by moving the top-row offset
    always_comb begin
        scroll   = 1'b0;
        row_step = row_reg;
        top_step = top_reg;
        col_step = col_reg + 1'b1;
        if (step_feed || (col_reg == CW'(COLUMNS - 1))) begin
            col_step = '0;
            if (row_reg == RW'(ROWS - 1)) begin
                scroll   = 1'b1;
                top_step = (top_reg == RW'(ROWS - 1)) ? '0 : top_reg + 1'b1;
            end else begin
                row_step = row_reg + 1'b1;
            end
        end
    end

    always_comb begin
        state_next     = state_reg;
        cmd_next       = cmd_reg;
        row_next       = row_reg;
        col_next       = col_reg;
        top_next       = top_reg;
        mat_next       = mat_reg;
        spc_next       = spc_reg;
        clr_attr_next  = clr_attr_reg;
        phys_next      = phys_reg;
        fill_next      = fill_reg;
        out_valid_next = out_valid_reg;
        out_data_next  = out_data_reg;
        out_row_next   = out_row_reg;
        out_col_next   = out_col_reg;
        q_pop          = 1'b0;
        mem_we         = 1'b0;
        mem_wa         = {phys, lcol};
        mem_wd         = put_val;
        mem_ra         = {phys, lcol};
        do_step        = 1'b0;
        step_feed      = 1'b0;
        emit           = 1'b0;
        emit_data      = '0;

        if (out_valid_reg && m_tready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            B_IDLE: begin
                // take a command only when the result register will be free
                if (q_valid && (!out_valid_reg || m_tready)) begin
                    q_pop      = 1'b1;
                    cmd_next   = q_cmd;
                    state_next = B_EXEC;
                end
            end
            B_EXEC: begin
                state_next = B_IDLE;
                case (cmd_reg.op)
                    OP_PUT: begin
                        if (mat_reg[phys]) begin
                            mem_we  = 1'b1;
                            do_step = 1'b1;
                            emit    = 1'b1;
                        end else begin
                            phys_next  = phys;
                            fill_next  = '0;
                            state_next = B_FILL;
                        end
                    end
                    OP_FEED: begin
                        do_step   = 1'b1;
                        step_feed = 1'b1;
                        emit      = 1'b1;
                    end
                    OP_CLEAR: begin
                        mat_next      = '0;
                        spc_next      = '1;
                        clr_attr_next = attr;
                        emit          = 1'b1;
                    end
                    OP_READ: begin
                        if (cmd_reg.outside) begin
                            emit = 1'b1;
                        end else if (!mat_reg[phys]) begin
                            emit      = 1'b1;
                            emit_data = virt_val;
                        end else begin
                            state_next = B_READ;
                        end
                    end
                    default: begin
                        emit = 1'b1;
                    end
                endcase
            end
            B_FILL: begin
                // write the row's blank value out, with the new character in place
                mem_we = 1'b1;
                mem_wa = {phys_reg, fill_reg};
                mem_wd = (fill_reg == col_reg) ? put_val : virt_val;
                if (fill_reg == CW'(COLUMNS - 1)) begin
                    mat_next[phys_reg] = 1'b1;
                    do_step            = 1'b1;
                    emit               = 1'b1;
                    state_next         = B_IDLE;
                end else begin
                    fill_next = fill_reg + 1'b1;
                end
            end
            B_READ: begin
                emit       = 1'b1;
                emit_data  = rd_reg;
                state_next = B_IDLE;
            end
            default: begin
                state_next = B_IDLE;
            end
        endcase

        if (do_step) begin
            row_next = row_step;
            col_next = col_step;
            top_next = top_step;
            if (scroll) begin
                // old top row comes round as the new bottom row, all zeros
                mat_next[top_reg] = 1'b0;
                spc_next[top_reg] = 1'b0;
            end
        end

        if (emit) begin
            out_valid_next = 1'b1;
            out_data_next  = emit_data;
            out_row_next   = do_step ? row_step : row_reg;
            out_col_next   = do_step ? col_step : col_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= B_IDLE;
            row_reg       <= '0;
            col_reg       <= '0;
            top_reg       <= '0;
            mat_reg       <= '0;
            spc_reg       <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            row_reg       <= row_next;
            col_reg       <= col_next;
            top_reg       <= top_next;
            mat_reg       <= mat_next;
            spc_reg       <= spc_next;
            out_valid_reg <= out_valid_next;
        end
        cmd_reg      <= cmd_next;
        clr_attr_reg <= clr_attr_next;
        phys_reg     <= phys_next;
        fill_reg     <= fill_next;
        out_data_reg <= out_data_next;
        out_row_reg  <= out_row_next;
        out_col_reg  <= out_col_next;
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        rd_reg <= mem[mem_ra];
    end

    assign m_tvalid        = out_valid_reg;
    assign m_read_data     = out_data_reg;
    assign m_cursor_row    = ROW_W'(out_row_reg);
    assign m_cursor_column = COL_W'(out_col_reg);

    `TTW_ASSERT_IMPL(a_pop_needs_room, aclk, aresetn, q_pop, (!out_valid_reg || m_tready), "command taken while result register busy")
    `TTW_ASSERT_NEXT(a_fill_sets_row, aclk, aresetn, (state_reg == B_FILL && fill_reg == CW'(COLUMNS - 1)), mat_reg[phys_reg], "row not marked after fill")
    `TTW_ASSERT_NEXT(a_clear_blanks_all, aclk, aresetn, (state_reg == B_EXEC && cmd_reg.op == OP_CLEAR), (mat_reg == '0 && spc_reg == '1), "clear left a stored row")

endmodule

// ----- design/text_terminal_writer.sv -----
// ----------------------------------------------------------------------------
// text_terminal_writer
// character terminal with a rows by columns screen of attribute/character cells
// ----------------------------------------------------------------------------
// Input transfers on s_ carry a kind in s_tuser (put, clear, read), the
// character and the cell index in s_tdata. Every accepted item gives exactly
// one result transfer on m_ with the read cell (zero unless a read) and the
// cursor position after the item. The user must write the attribute for new
// characters and clears over the cfg_ channel only while the block is idle;
// the block itself does not enforce this. Each item passes the decoder's
// output register, the command queue, the engine's execute state and the
// result register. A put into a row not yet held in the cell memory first
// writes that row out through the single memory write port; a read inside
// the screen first splits the index by one subtraction per row of the index
// (up to ROWS - 1), then reads the cell memory when the row is held there.
// The decoder takes a new item only once its last command is in the queue,
// and the engine works on one command at a time. Scrolling only moves a
// top-row offset and clear marks every row blank at once.
// After reset the screen reads as all zeros, the cursor is at row 0 column 0
// and the attribute is 7; no clearing pass is needed. When the receiver
// stalls, the result holds in the output register while the decoder keeps
// taking items into a short command queue until it fills.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module text_terminal_writer #(
    parameter int COLUMNS     = ttw_pkg::COLUMNS_DEFAULT,
    parameter int ROWS        = ttw_pkg::ROWS_DEFAULT,
    parameter int QUEUE_DEPTH = ttw_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [23:0]  s_tdata,   // char_code[7:0], cell_index[18:8], zero fill
    input  logic [1:0]   s_tuser,   // kind[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [31:0]  m_tdata,   // read_data[15:0], cursor_row[20:16],
                                    // cursor_column[27:21], zero fill
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [7:0]   cfg_data   // text_attribute
);
    import ttw_pkg::*;

    logic [ATTR_W-1:0]  attr_reg;
    logic               q_in_valid, q_in_ready, q_out_valid, q_pop;
    cmd_t               q_in_cmd, q_out_cmd;
    logic [DATA_W-1:0]  read_data;
    logic [ROW_W-1:0]   cursor_row;
    logic [COL_W-1:0]   cursor_column;

    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            attr_reg <= ATTR_RESET;
        end else if (cfg_valid && cfg_ready) begin
            attr_reg <= cfg_data;
        end
    end

    ttw_front #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_kind   (s_tuser),
        .s_code   (s_tdata[7:0]),
        .s_index  (s_tdata[18:8]),
        .q_valid  (q_in_valid),
        .q_ready  (q_in_ready),
        .q_cmd    (q_in_cmd)
    );

    ttw_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_valid  (q_in_valid),
        .in_ready  (q_in_ready),
        .in_cmd    (q_in_cmd),
        .out_valid (q_out_valid),
        .out_ready (q_pop),
        .out_cmd   (q_out_cmd)
    );

    ttw_back #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_back (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .attr            (attr_reg),
        .q_valid         (q_out_valid),
        .q_cmd           (q_out_cmd),
        .q_pop           (q_pop),
        .m_tvalid        (m_tvalid),
        .m_tready        (m_tready),
        .m_read_data     (read_data),
        .m_cursor_row    (cursor_row),
        .m_cursor_column (cursor_column)
    );

    assign m_tdata = {4'd0, cursor_column, cursor_row, read_data};

endmodule
